@@ design/bresenham_line_raster_defines.svh @@
// ----------------------------------------------------------------------------
// Bresenham line raster - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTER_DEFINES_SVH
`define BRESENHAM_LINE_RASTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bresenham_line_raster: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bresenham_line_raster: next-cycle check failed");

`endif

@@ design/blr_pkg.sv @@
// ----------------------------------------------------------------------------
// blr_pkg
// Types, widths and helpers shared by the line raster modules.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int unsigned COORD_X_W       = 6;
    localparam int unsigned COORD_Y_W       = 5;
    localparam int unsigned PEN_W           = 8;
    // decision term stays within +/- 2*63
    localparam int unsigned DEC_W           = 9;
    localparam int unsigned DEF_GRID_WIDTH  = 64;
    localparam int unsigned DEF_GRID_HEIGHT = 32;
    localparam logic [PEN_W-1:0] PEN_RESET  = 8'd1;

    typedef struct packed {
        logic [COORD_X_W-1:0] start_x;
        logic [COORD_Y_W-1:0] start_y;
        logic [COORD_X_W-1:0] end_x;
        logic [COORD_Y_W-1:0] end_y;
    } line_cmd_t;

    typedef struct packed {
        logic [COORD_X_W-1:0] pixel_x;
        logic [COORD_Y_W-1:0] pixel_y;
        logic [PEN_W-1:0]     pixel_value;
        logic                 last_pixel;
    } pixel_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture command and pen
        logic init;   // compute deltas and decision
        logic step;   // emit current pixel, advance
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;   // current pixel is the end point
    } ctrl_status_t;

    // clamp a column to the grid
    function automatic logic [COORD_X_W-1:0] sat_x(logic [COORD_X_W-1:0] v,
                                                   int unsigned limit);
        logic [COORD_X_W-1:0] r;
        if (32'(v) >= limit)
            r = COORD_X_W'(limit - 1);
        else
            r = v;
        return r;
    endfunction

    // clamp a row to the grid
    function automatic logic [COORD_Y_W-1:0] sat_y(logic [COORD_Y_W-1:0] v,
                                                   int unsigned limit);
        logic [COORD_Y_W-1:0] r;
        if (32'(v) >= limit)
            r = COORD_Y_W'(limit - 1);
        else
            r = v;
        return r;
    endfunction

endpackage

@@ design/bresenham_line_raster.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_raster
// Integer Bresenham line rasterizer, one pixel transaction per cycle while a line is drawn.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the command is taken at a
//   clock edge where start is high and busy is low. busy then stays high
//   until the last pixel of the line has left the sequencer.
//   Result channel: each pixel is a transaction shown on pixel for exactly
//   one cycle with strobe high. The receiver cannot hold results off, so
//   there is no stall path; it must take every strobe.
//   Pen register: pen_we/pen_data write the pen value (reset value 1) at
//   any edge; it is sampled when a command is taken, so write it while idle.
// Timing:
//   The first pixel appears after the accepting edge once the setup step
//   (deltas and the decision term) and then the first draw step are done,
//   after which pixels follow back to back, max(|dx|,|dy|)+1 of them.
//   busy drops in the cycle the last pixel is shown, so a new command is
//   taken only once the whole line is out. The draw loop, one step of the
//   shared coordinate/decision update per cycle, sets how often that is.
// Reset: rst_n (async, low) returns the sequencer to idle, clears strobe
//   and loads the pen register with 1.
// ----------------------------------------------------------------------------
module bresenham_line_raster
    import blr_pkg::*;
#(
    parameter int unsigned GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int unsigned GRID_HEIGHT = DEF_GRID_HEIGHT
)
(
    input  logic             clk,
    input  logic             rst_n,
    // command transaction
    input  logic             start,
    output logic             busy,
    input  line_cmd_t        cmd,
    // pen register write
    input  logic             pen_we,
    input  logic [PEN_W-1:0] pen_data,
    // pixel transaction
    output logic             strobe,
    output pixel_t           pixel
);

    ctrl_cmd_t    ctrl_cmd;
    ctrl_status_t ctrl_status;

    // sequencer: idle -> setup -> draw (one step per cycle) -> idle
    blr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (ctrl_cmd),
        .status (ctrl_status)
    );

    // coordinates, decision term and output register
    blr_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .line_in  (cmd),
        .pen_we   (pen_we),
        .pen_data (pen_data),
        .cmd      (ctrl_cmd),
        .status   (ctrl_status),
        .strobe   (strobe),
        .pixel    (pixel)
    );

endmodule

@@ design/blr_ctrl.sv @@
// ----------------------------------------------------------------------------
// blr_ctrl
// Sequencer: idle, setup of the decision terms, then one pixel per cycle.
// ----------------------------------------------------------------------------
module blr_ctrl
    import blr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    output ctrl_cmd_t    cmd,
    input  ctrl_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DRAW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        cmd.load = start & ~busy_reg;
        cmd.init = (state_reg == ST_SETUP);
        cmd.step = (state_reg == ST_DRAW);
    end

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SETUP;
                    busy_next  = 1'b1;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                if (status.last)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

@@ design/blr_datapath.sv @@
// ----------------------------------------------------------------------------
// blr_datapath
// Pen register, coordinate and decision registers, pixel output register.
// ----------------------------------------------------------------------------
module blr_datapath
    import blr_pkg::*;
#(
    parameter int unsigned GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int unsigned GRID_HEIGHT = DEF_GRID_HEIGHT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  line_cmd_t        line_in,
    input  logic             pen_we,
    input  logic [PEN_W-1:0] pen_data,
    input  ctrl_cmd_t        cmd,
    output ctrl_status_t     status,
    output logic             strobe,
    output pixel_t           pixel
);

    logic [PEN_W-1:0]            pen_cfg_reg;
    logic [PEN_W-1:0]            pen_reg;
    logic [COORD_X_W-1:0]        x_reg;
    logic [COORD_X_W-1:0]        x_next;
    logic [COORD_Y_W-1:0]        y_reg;
    logic [COORD_Y_W-1:0]        y_next;
    logic [COORD_X_W-1:0]        ex_reg;
    logic [COORD_Y_W-1:0]        ey_reg;
    logic [COORD_X_W-1:0]        dx_reg;
    logic [COORD_X_W-1:0]        dy_reg;
    logic [COORD_X_W-1:0]        steps_reg;
    logic [COORD_X_W-1:0]        cnt_reg;
    logic                        xmajor_reg;
    logic                        sx_neg_reg;
    logic                        sy_neg_reg;
    logic signed [DEC_W-1:0]     dec_reg;
    logic signed [DEC_W-1:0]     dec_next;
    logic                        strobe_reg;
    pixel_t                      pixel_reg;

    // setup terms
    logic [COORD_X_W-1:0]        dx_init;
    logic [COORD_X_W-1:0]        dy_init;
    logic                        xmajor_init;
    logic signed [DEC_W-1:0]     two_dx_init;
    logic signed [DEC_W-1:0]     two_dy_init;

    // step terms
    logic signed [DEC_W-1:0]     two_dx;
    logic signed [DEC_W-1:0]     two_dy;
    logic                        minor;
    logic [COORD_X_W-1:0]        x_inc;
    logic [COORD_Y_W-1:0]        y_inc;
    logic                        last;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pen_cfg_reg <= PEN_RESET;
        else if (pen_we)
            pen_cfg_reg <= pen_data;
    end

    always_comb
    begin
        dx_init     = (ex_reg >= x_reg) ? ex_reg - x_reg : x_reg - ex_reg;
        dy_init     = (COORD_X_W'(ey_reg) >= COORD_X_W'(y_reg))
                    ? COORD_X_W'(ey_reg) - COORD_X_W'(y_reg)
                    : COORD_X_W'(y_reg) - COORD_X_W'(ey_reg);
        xmajor_init = dx_init > dy_init;
        two_dx_init = signed'(DEC_W'({dx_init, 1'b0}));
        two_dy_init = signed'(DEC_W'({dy_init, 1'b0}));
    end

    always_comb
    begin
        two_dx   = signed'(DEC_W'({dx_reg, 1'b0}));
        two_dy   = signed'(DEC_W'({dy_reg, 1'b0}));
        minor    = ~dec_reg[DEC_W-1];
        x_inc    = sx_neg_reg ? '1 : COORD_X_W'(1);
        y_inc    = sy_neg_reg ? '1 : COORD_Y_W'(1);
        last     = (cnt_reg == steps_reg);
        x_next   = x_reg;
        y_next   = y_reg;
        dec_next = dec_reg;
        if (xmajor_reg)
        begin
            x_next = x_reg + x_inc;
            if (minor)
            begin
                y_next   = y_reg + y_inc;
                dec_next = dec_reg - two_dx + two_dy;
            end
            else
                dec_next = dec_reg + two_dy;
        end
        else
        begin
            y_next = y_reg + y_inc;
            if (minor)
            begin
                x_next   = x_reg + x_inc;
                dec_next = dec_reg - two_dy + two_dx;
            end
            else
                dec_next = dec_reg + two_dx;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sat_x(line_in.start_x, GRID_WIDTH);
            y_reg   <= sat_y(line_in.start_y, GRID_HEIGHT);
            ex_reg  <= sat_x(line_in.end_x, GRID_WIDTH);
            ey_reg  <= sat_y(line_in.end_y, GRID_HEIGHT);
            pen_reg <= pen_cfg_reg;
        end
        else if (cmd.init)
        begin
            dx_reg     <= dx_init;
            dy_reg     <= dy_init;
            xmajor_reg <= xmajor_init;
            steps_reg  <= xmajor_init ? dx_init : dy_init;
            dec_reg    <= xmajor_init ? two_dy_init - signed'(DEC_W'(dx_init))
                                      : two_dx_init - signed'(DEC_W'(dy_init));
            sx_neg_reg <= ~(x_reg < ex_reg);
            sy_neg_reg <= ~(y_reg < ey_reg);
            cnt_reg    <= '0;
        end
        else if (cmd.step)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            dec_reg <= dec_next;
            cnt_reg <= cnt_reg + COORD_X_W'(1);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.step;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            pixel_reg.pixel_x     <= x_reg;
            pixel_reg.pixel_y     <= y_reg;
            pixel_reg.pixel_value <= pen_reg;
            pixel_reg.last_pixel  <= last;
        end
    end

    assign status.last = last;
    assign strobe      = strobe_reg;
    assign pixel       = pixel_reg;

endmodule

@@ design/blr_checker.sv @@
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks of the line raster, bound to the top level.
// ----------------------------------------------------------------------------
`include "bresenham_line_raster_defines.svh"

module blr_checker
    import blr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             strobe,
    input pixel_t           pixel
);

    `BLR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `BLR_ASSERT_IMPLY(a_busy_ends_on_last, clk, rst_n, $fell(busy),
                      strobe && pixel.last_pixel)
    `BLR_ASSERT_NEXT(a_run_contiguous, clk, rst_n, strobe && !pixel.last_pixel, strobe)
    `BLR_ASSERT_NEXT(a_pen_steady, clk, rst_n, strobe && !pixel.last_pixel,
                     pixel.pixel_value == $past(pixel.pixel_value))

endmodule

bind bresenham_line_raster blr_checker u_blr_checker (.*);
